// ===== rtl/core/mcw_pkg.sv =====
// Shared types and codes for the multi-channel watchdog core.
`timescale 1ns / 1ps

package mcw_pkg;

  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_KICK     = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_QUERY    = 2'd3
  } req_e_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_DUPLICATE = 2'd1,
    ERR_FULL      = 2'd2,
    ERR_UNKNOWN   = 2'd3
  } err_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_DONE
  } state_t;

  // One table row: id, timeout, elapsed time and the sticky expired mark.
  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] timeout;
    logic [31:0] elapsed;
    logic        expired;
  } row_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
    logic emit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } ctl_sts_t;

endpackage

// ===== rtl/core/multi_channel_watchdog_core.sv =====
// Top level of the multi-channel watchdog core: controller plus datapath.
`timescale 1ns / 1ps

// The core keeps a table of up to MAX_CHANNELS watchdog channels, each keyed
// by an 8-bit id with its own timeout. Requests arrive on a valid/ready input
// channel; req_type selects register, kick, tick or query. Every request
// produces exactly one result transfer on the valid/ready output channel,
// carrying error_code, any_expired and channel_expired.
// Each request walks the channel table with one registered memory read per
// cycle. One request is processed at a time; in_ready returns the cycle
// after the result is loaded into the output register, so a new request is
// taken only once the previous result has been loaded there.
// Reset clears the channel count and all control state; table contents are
// not cleared because only slots below the channel count are ever read.
// When the receiver stalls, the result holds in the output register; the
// core still accepts and processes one further request, then waits with its
// result until the output register frees up.
module multi_channel_watchdog_core #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  channel_id,
  input  logic [31:0] deadline_ms,
  input  logic [31:0] tick_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  error_code,
  output logic        any_expired,
  output logic        channel_expired
);
  import mcw_pkg::*;

  // Command and status between the sequencer and the datapath.
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  mcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mcw_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .req_type        (req_type),
    .channel_id      (channel_id),
    .deadline_ms     (deadline_ms),
    .tick_ms         (tick_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .error_code      (error_code),
    .any_expired     (any_expired),
    .channel_expired (channel_expired)
  );

endmodule

// ===== rtl/core/mcw_ctrl.sv =====
// Controller state machine that sequences one request through the datapath.
`timescale 1ns / 1ps

module mcw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mcw_pkg::ctl_sts_t sts,
  output mcw_pkg::ctl_cmd_t cmd
);
  import mcw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/mcw_datapath.sv =====
// Datapath: channel table memory, table walk, tick update and result register.
`timescale 1ns / 1ps

module mcw_datapath #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  mcw_pkg::ctl_cmd_t cmd,
  output mcw_pkg::ctl_sts_t sts,
  input  logic [1:0]        req_type,
  input  logic [7:0]        channel_id,
  input  logic [31:0]       deadline_ms,
  input  logic [31:0]       tick_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        error_code,
  output logic              any_expired,
  output logic              channel_expired
);
  import mcw_pkg::*;

  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  row_t mem [MAX_CHANNELS];

  // Request captured at the input transfer.
  req_e_t      req_q;
  logic [7:0]  id_q;
  logic [31:0] timeout_q;
  logic [31:0] tick_q;

  logic [CW-1:0] used_count;
  logic [CW-1:0] issue_cnt;
  logic          rd_pend;
  logic [IW-1:0] rd_slot;
  row_t          rd_row;

  logic          found;
  logic [IW-1:0] found_slot;
  row_t          found_row;
  logic          any_acc;

  logic [1:0] res_err;
  logic       res_any;
  logic       res_hit;
  logic [1:0] res_err_next;
  logic       res_any_next;
  logic       res_hit_next;

  logic          rd_en;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  row_t          wr_row;

  logic [32:0] sum_wide;
  logic [31:0] sum_sat;
  logic        exp_new;
  row_t        tick_row;

  assign rd_en = cmd.scan && (issue_cnt != used_count);

  assign sum_wide = {1'b0, rd_row.elapsed} + {1'b0, tick_q};
  assign sum_sat  = sum_wide[32] ? '1 : sum_wide[31:0];
  assign exp_new  = rd_row.expired || (sum_sat >= rd_row.timeout);

  always_comb begin
    tick_row         = rd_row;
    tick_row.elapsed = sum_sat;
    tick_row.expired = exp_new;
  end

  // Single write port: tick writeback during the walk, or the finishing update.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_slot;
    wr_row  = tick_row;
    if (rd_pend && (req_q == REQ_TICK)) begin
      wr_en = 1'b1;
    end else if (cmd.finish) begin
      unique case (req_q)
        REQ_REGISTER: begin
          wr_en          = !found && (used_count != CW'(MAX_CHANNELS));
          wr_addr        = used_count[IW-1:0];
          wr_row.id      = id_q;
          wr_row.timeout = timeout_q;
          wr_row.elapsed = '0;
          wr_row.expired = 1'b0;
        end
        REQ_KICK: begin
          wr_en          = found;
          wr_addr        = found_slot;
          wr_row         = found_row;
          wr_row.elapsed = '0;
          wr_row.expired = 1'b0;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[issue_cnt[IW-1:0]];
    end
  end

  // Walk control.
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      rd_pend   <= 1'b0;
    end else if (cmd.load) begin
      issue_cnt <= '0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (rd_en) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_slot <= issue_cnt[IW-1:0];
    end
  end

  assign sts.scan_done = (issue_cnt == used_count) && !rd_pend;

  // Request capture and match/any accumulation.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q     <= req_e_t'(req_type);
      id_q      <= channel_id;
      timeout_q <= deadline_ms;
      tick_q    <= tick_ms;
      found     <= 1'b0;
      any_acc   <= 1'b0;
    end else if (rd_pend) begin
      if (rd_row.id == id_q) begin
        found      <= 1'b1;
        found_slot <= rd_slot;
        found_row  <= rd_row;
      end
      if ((req_q == REQ_TICK) && exp_new) begin
        any_acc <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (cmd.finish && (req_q == REQ_REGISTER) && !found
                 && (used_count != CW'(MAX_CHANNELS))) begin
      used_count <= used_count + 1'b1;
    end
  end

  // Result of the finishing step.
  always_comb begin
    res_err_next = ERR_NONE;
    res_any_next = 1'b0;
    res_hit_next = 1'b0;
    unique case (req_q)
      REQ_REGISTER: begin
        if (found) begin
          res_err_next = ERR_DUPLICATE;
        end else if (used_count == CW'(MAX_CHANNELS)) begin
          res_err_next = ERR_FULL;
        end
      end
      REQ_KICK: begin
        if (!found) begin
          res_err_next = ERR_UNKNOWN;
        end
      end
      REQ_TICK: begin
        res_any_next = any_acc;
      end
      REQ_QUERY: begin
        res_hit_next = found && found_row.expired;
      end
      default: begin
        res_err_next = ERR_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_err <= res_err_next;
      res_any <= res_any_next;
      res_hit <= res_hit_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      error_code      <= res_err;
      any_expired     <= res_any;
      channel_expired <= res_hit;
    end
  end

  assign sts.out_busy = out_valid && !out_ready;

endmodule
